// ===== rtl/moving_average_level_meter_assert.svh =====
// Assertion macros for the level meter.
`ifndef MOVING_AVERAGE_LEVEL_METER_ASSERT_SVH
`define MOVING_AVERAGE_LEVEL_METER_ASSERT_SVH

// Check that cond implies prop in the same cycle.
`define MAVLM_ASSERT_SAME(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Check that cond implies prop in the following cycle.
`define MAVLM_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== rtl/mavlm_pkg.sv =====
package mavlm_pkg;

   localparam int CFG_BITS       = 10;
   localparam int AVG_BITS       = 10;
   localparam int FLAG_BITS      = 5;
   localparam int CSR_INDEX_BITS = 8;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD_ONE   = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD_TWO   = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD_THREE = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD_FOUR  = 8'd3;

   localparam logic [CFG_BITS-1:0] THRESHOLD_ONE_RESET   = 10'd200;
   localparam logic [CFG_BITS-1:0] THRESHOLD_TWO_RESET   = 10'd400;
   localparam logic [CFG_BITS-1:0] THRESHOLD_THREE_RESET = 10'd600;
   localparam logic [CFG_BITS-1:0] THRESHOLD_FOUR_RESET  = 10'd800;

   typedef struct packed {
      logic [CFG_BITS-1:0] one;
      logic [CFG_BITS-1:0] two;
      logic [CFG_BITS-1:0] three;
      logic [CFG_BITS-1:0] four;
   } thresholds_type;

endpackage

// ===== rtl/mavlm_cell.sv =====
module mavlm_cell #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   shift,
   input  logic [SAMPLE_BITS-1:0] data_in,
   output logic [SAMPLE_BITS-1:0] data_out
);

   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [SAMPLE_BITS-1:0] sample_in;

   // take the neighbour's sample on a shift, hold otherwise
   assign sample_in = shift ? data_in : sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in;
      end
   end

   assign data_out = sample_ff;

endmodule

// ===== rtl/mavlm_levels.sv =====
module mavlm_levels #(
   parameter int VALUE_BITS = 10
) (
   input  logic [VALUE_BITS-1:0]          value,
   input  mavlm_pkg::thresholds_type      thresholds,
   output logic [mavlm_pkg::FLAG_BITS-1:0] flags
);

   logic [VALUE_BITS-1:0] t1;
   logic [VALUE_BITS-1:0] t2;
   logic [VALUE_BITS-1:0] t3;
   logic [VALUE_BITS-1:0] t4;

   assign t1 = VALUE_BITS'(thresholds.one);
   assign t2 = VALUE_BITS'(thresholds.two);
   assign t3 = VALUE_BITS'(thresholds.three);
   assign t4 = VALUE_BITS'(thresholds.four);

   // inclusive bounds: a value on a threshold lights both neighbouring bands
   always_comb begin
      flags[0] = (value <= t1);
      flags[1] = (value >= t1) && (value <= t2);
      flags[2] = (value >= t2) && (value <= t3);
      flags[3] = (value >= t3) && (value <= t4);
      flags[4] = (value >= t4);
   end

endmodule

// ===== rtl/moving_average_level_meter.sv =====
// Moving-average level meter.
// Sample beats enter on req_valid/req_ready with req_sample; each accepted
// beat produces exactly one result beat on rsp_valid/rsp_ready carrying
// rsp_average (window sum over WINDOW_LENGTH, truncated) and rsp_level_flags
// (one bit per band of the bar graph, bounds inclusive).
// Thresholds are written on the csr_ channel: index 0 to 3 select threshold
// one to four, other indexes are dropped; csr_ready is always high. Write
// them only while no beat is in flight.
// Throughput: one beat per cycle while rsp_ready keeps the output moving, set
// by the running-sum update beside the shift chain of sample cells.
// A beat passes three registered stages from req accept to rsp_valid (sum
// update, reciprocal multiply, compare and output register).
// Reset clears the sample cells, the running sum and every valid bit at once
// and restores the threshold defaults 200, 400, 600, 800; no clearing pass,
// req_ready is high in the first cycle after reset.
// When the receiver stalls the result holds in the output register, the
// beats behind it close up, and req_ready drops once all three stages are
// full.
module moving_average_level_meter #(
   parameter int WINDOW_LENGTH = 16,
   parameter int SAMPLE_BITS   = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [SAMPLE_BITS-1:0]               req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [mavlm_pkg::AVG_BITS-1:0]       rsp_average,
   output logic [mavlm_pkg::FLAG_BITS-1:0]      rsp_level_flags,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mavlm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mavlm_pkg::CFG_BITS-1:0]       csr_data
);

`include "moving_average_level_meter_assert.svh"

   // Sum width covers a full window of maximum samples
   localparam int WIN_LOG  = $clog2(WINDOW_LENGTH);
   localparam int SUM_W    = SAMPLE_BITS + WIN_LOG;
   // Exact division by the window: multiply by ceil(2^SHIFT / WINDOW_LENGTH)
   localparam int SHIFT    = SUM_W + WIN_LOG;
   localparam int RECIP_W  = SUM_W + 2;
   localparam longint unsigned RECIP_VAL =
      ((64'd1 << SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
   localparam int PROD_W   = SUM_W + RECIP_W;
   localparam int CMP_W    = (SAMPLE_BITS > mavlm_pkg::CFG_BITS) ?
                             SAMPLE_BITS : mavlm_pkg::CFG_BITS;
   localparam logic [SUM_W-1:0] SUM_MAX =
      SUM_W'(WINDOW_LENGTH * ((1 << SAMPLE_BITS) - 1));

   // ---------------- configuration ----------------
   mavlm_pkg::thresholds_type thresholds_ff;
   mavlm_pkg::thresholds_type thresholds_in;

   assign csr_ready = 1'b1;

   always_comb begin
      thresholds_in = thresholds_ff;
      if (csr_valid) begin
         case (csr_index)
            mavlm_pkg::CSR_THRESHOLD_ONE:   thresholds_in.one   = csr_data;
            mavlm_pkg::CSR_THRESHOLD_TWO:   thresholds_in.two   = csr_data;
            mavlm_pkg::CSR_THRESHOLD_THREE: thresholds_in.three = csr_data;
            mavlm_pkg::CSR_THRESHOLD_FOUR:  thresholds_in.four  = csr_data;
            default:                        thresholds_in = thresholds_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresholds_ff.one   <= mavlm_pkg::THRESHOLD_ONE_RESET;
         thresholds_ff.two   <= mavlm_pkg::THRESHOLD_TWO_RESET;
         thresholds_ff.three <= mavlm_pkg::THRESHOLD_THREE_RESET;
         thresholds_ff.four  <= mavlm_pkg::THRESHOLD_FOUR_RESET;
      end else begin
         thresholds_ff <= thresholds_in;
      end
   end

   // ---------------- pipeline flow control ----------------
   // Each stage advances when the one after it is empty or advancing, so
   // bubbles close up behind a stalled output register.
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic adv1, adv2, adv3;
   logic accept;

   assign adv3      = !rsp_valid_ff || rsp_ready;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_ready = adv1;
   assign accept    = req_valid && adv1;

   assign s1_valid_in  = adv1 ? req_valid   : s1_valid_ff;
   assign s2_valid_in  = adv2 ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = adv3 ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- stage 1: window chain and running sum ----------------
   // The chain shifts once per accepted beat; the last cell holds the sample
   // that drops out of the window (zero until the window has filled).
   logic [SAMPLE_BITS-1:0] tap [WINDOW_LENGTH];

   for (genvar i = 0; i < WINDOW_LENGTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         mavlm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (accept),
            .data_in  (req_sample),
            .data_out (tap[i])
         );
      end else begin : g_body
         mavlm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (accept),
            .data_in  (tap[i-1]),
            .data_out (tap[i])
         );
      end
   end

   logic [SUM_W-1:0] window_sum_ff;
   logic [SUM_W-1:0] window_sum_in;

   // add the newcomer, subtract the oldest; the sum always matches the cells
   assign window_sum_in = accept ?
      (window_sum_ff + SUM_W'(req_sample) - SUM_W'(tap[WINDOW_LENGTH-1])) :
      window_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_sum_ff <= '0;
      end else begin
         window_sum_ff <= window_sum_in;
      end
   end

   // ---------------- stage 2: reciprocal multiply ----------------
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = adv2 ? (PROD_W'(window_sum_ff) * PROD_W'(RECIP)) : prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // ---------------- stage 3: band compare and output register ----------------
   logic [CMP_W-1:0]                  avg_wide;
   logic [mavlm_pkg::FLAG_BITS-1:0]   flags;
   logic [mavlm_pkg::AVG_BITS-1:0]    average_ff, average_in;
   logic [mavlm_pkg::FLAG_BITS-1:0]   flags_ff, flags_in;

   assign avg_wide = CMP_W'(prod_ff >> SHIFT);

   mavlm_levels #(
      .VALUE_BITS (CMP_W)
   ) u_levels (
      .value      (avg_wide),
      .thresholds (thresholds_ff),
      .flags      (flags)
   );

   assign average_in = adv3 ? mavlm_pkg::AVG_BITS'(avg_wide) : average_ff;
   assign flags_in   = adv3 ? flags : flags_ff;

   always_ff @(posedge clock) begin
      average_ff <= average_in;
      flags_ff   <= flags_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_average     = average_ff;
   assign rsp_level_flags = flags_ff;

   // ---------------- assertions ----------------
   `MAVLM_ASSERT_SAME(a_ready_only_when_full, clock, reset,
      !req_ready, s1_valid_ff && s2_valid_ff && rsp_valid_ff,
      "req_ready low with a free pipeline stage")
   `MAVLM_ASSERT_NEXT(a_accept_fills_stage1, clock, reset,
      req_valid && req_ready, s1_valid_ff,
      "accepted beat lost before stage two")
   `MAVLM_ASSERT_NEXT(a_stage2_holds, clock, reset,
      s2_valid_ff && rsp_valid_ff && !rsp_ready,
      s2_valid_ff && $stable(prod_ff),
      "stage two changed behind a stalled output")
   `MAVLM_ASSERT_SAME(a_sum_bounded, clock, reset,
      1'b1, window_sum_ff <= SUM_MAX,
      "running sum beyond a full window of maximum samples")

endmodule
